// ===== rtl/core/psdiv_pkg.sv =====
// shared types and constants for the power series divide unit
package psdiv_pkg;

    localparam int MAX_TERMS = 1024;
    localparam int IDX_W     = $clog2(MAX_TERMS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int TERM_W    = 30;

    localparam logic [TERM_W-1:0] PRIME = 30'd998244353;

    // barrett constant floor(2^60 / prime)
    localparam logic [60:0] MU_FULL = (61'd1 << 60) / {31'd0, PRIME};
    localparam logic [30:0] MU      = MU_FULL[30:0];

    typedef struct packed {
        logic [TERM_W-1:0] dividend_term;
        logic [TERM_W-1:0] divisor_term;
        logic              series_end;
    } in_t;

    typedef struct packed {
        logic [TERM_W-1:0] quotient_term;
        logic              end_of_series;
        logic              too_many_terms;
    } out_t;

    typedef struct packed {
        logic valid;
        logic clear;
    } mac_ctl_t;

endpackage

// ===== rtl/core/psdiv_mac.sv =====
// pipelined modular multiply-accumulate unit with barrett reduction
module psdiv_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  psdiv_pkg::mac_ctl_t                 ctl,
    input  logic [psdiv_pkg::TERM_W-1:0]        opa,
    input  logic [psdiv_pkg::TERM_W-1:0]        opb,
    output logic [psdiv_pkg::TERM_W-1:0]        acc,
    output logic                                busy
);

    logic                              v1_reg, v2_reg, v3_reg, v4_reg;
    logic [59:0]                       prod_reg;
    logic [30:0]                       qest_reg;
    logic [31:0]                       lo2_reg;
    logic [31:0]                       qp_reg;
    logic [31:0]                       lo3_reg;
    logic [psdiv_pkg::TERM_W-1:0]      r_reg;
    logic [psdiv_pkg::TERM_W-1:0]      acc_reg;

    logic [59:0]                       prod_next;
    logic [61:0]                       t_full;
    logic [30:0]                       qest_next;
    logic [60:0]                       qp_full;
    logic [31:0]                       diff;
    logic [31:0]                       p1_ext;
    logic [31:0]                       p2_ext;
    logic [psdiv_pkg::TERM_W-1:0]      r_next;
    logic [psdiv_pkg::TERM_W:0]        sum;
    logic [psdiv_pkg::TERM_W:0]        sum_red;
    logic [psdiv_pkg::TERM_W-1:0]      acc_next;

    assign prod_next = {30'd0, opa} * {30'd0, opb};
    assign t_full    = {31'd0, prod_reg[59:29]} * {31'd0, psdiv_pkg::MU};
    assign qest_next = t_full[61:31];
    assign qp_full   = {30'd0, qest_reg} * {31'd0, psdiv_pkg::PRIME};

    // remainder estimate is below three times the prime
    assign p1_ext = {2'd0, psdiv_pkg::PRIME};
    assign p2_ext = {1'b0, psdiv_pkg::PRIME, 1'b0};
    assign diff   = lo3_reg - qp_reg;

    always_comb
    begin
        if (diff >= p2_ext)
        begin
            r_next = psdiv_pkg::TERM_W'(diff - p2_ext);
        end
        else if (diff >= p1_ext)
        begin
            r_next = psdiv_pkg::TERM_W'(diff - p1_ext);
        end
        else
        begin
            r_next = diff[psdiv_pkg::TERM_W-1:0];
        end
    end

    assign sum     = {1'b0, acc_reg} + {1'b0, r_reg};
    assign sum_red = sum - {1'b0, psdiv_pkg::PRIME};

    always_comb
    begin
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (v4_reg)
        begin
            if (sum >= {1'b0, psdiv_pkg::PRIME})
            begin
                acc_next = sum_red[psdiv_pkg::TERM_W-1:0];
            end
            else
            begin
                acc_next = sum[psdiv_pkg::TERM_W-1:0];
            end
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            v1_reg  <= ctl.valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        qest_reg <= qest_next;
        lo2_reg  <= prod_reg[31:0];
        qp_reg   <= qp_full[31:0];
        lo3_reg  <= lo2_reg;
        r_reg    <= r_next;
    end

    assign acc  = acc_reg;
    assign busy = v1_reg | v2_reg | v3_reg | v4_reg;

endmodule

// ===== rtl/core/power_series_divide_mod_prime_unit.sv =====
// top level: sequencer and term stores for online power series division mod 998244353
//
// Each accepted transaction carries the next dividend and divisor coefficient of a series
// and yields one quotient coefficient q[i] = a[i] - sum_{j<i} q[j]*b[i-j] mod 998244353.
// The divisor constant term is taken as one. One shared pipelined modular
// multiply-accumulate unit is fed one product per cycle from the single read port of each
// term store. Term i (i >= 1) takes i reads. The store read register, the four-stage
// multiply-reduce pipeline and the accumulator then drain. Term zero and terms at index
// MAX_TERMS or above need no products and go straight to the done state. Terms at index
// MAX_TERMS or above come back with too_many_terms set and a zero quotient, and are not
// stored. series_end resets the index for the next series. The stores need no clearing
// after reset, so the unit is ready right away. The input side stalls while a term is
// being worked on, and while a finished term waits for a stalled output register. A
// finished result waits in the output register while the next transaction is accepted.
module power_series_divide_mod_prime_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              term_valid,
    output logic              term_stall,
    input  psdiv_pkg::in_t    term_data,
    output logic              quot_valid,
    input  logic              quot_stall,
    output psdiv_pkg::out_t   quot_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t                             state_reg, state_next;
    logic [psdiv_pkg::CNT_W-1:0]        idx_reg, idx_next;
    logic [psdiv_pkg::IDX_W-1:0]        j_reg, j_next;
    logic [psdiv_pkg::TERM_W-1:0]       a_reg, a_next;
    logic                               last_reg, last_next;
    logic                               over_reg, over_next;
    logic                               rd_valid_reg, rd_valid_next;
    logic                               quot_valid_reg, quot_valid_next;
    psdiv_pkg::out_t                    quot_data_reg, quot_data_next;

    logic [psdiv_pkg::TERM_W-1:0]       div_mem [psdiv_pkg::MAX_TERMS];
    logic [psdiv_pkg::TERM_W-1:0]       quo_mem [psdiv_pkg::MAX_TERMS];
    logic [psdiv_pkg::TERM_W-1:0]       div_rd_reg;
    logic [psdiv_pkg::TERM_W-1:0]       quo_rd_reg;

    logic                               accept;
    logic                               idx_over;
    logic [psdiv_pkg::TERM_W-1:0]       a_red;
    logic [psdiv_pkg::TERM_W-1:0]       b_red;
    logic                               div_we;
    logic                               quo_we;
    logic                               rd_en;
    logic [psdiv_pkg::CNT_W-1:0]        div_diff;
    logic [psdiv_pkg::IDX_W-1:0]        div_raddr;
    logic                               run_last;
    logic                               out_free;
    logic [psdiv_pkg::TERM_W-1:0]       q_val;
    logic [psdiv_pkg::TERM_W-1:0]       acc;
    logic                               mac_busy;
    psdiv_pkg::mac_ctl_t                mac_ctl;

    assign term_stall = (state_reg != S_IDLE);
    assign accept     = term_valid && !term_stall;
    assign idx_over   = (idx_reg >= psdiv_pkg::CNT_W'(psdiv_pkg::MAX_TERMS));

    // inputs are below twice the prime
    assign a_red = (term_data.dividend_term >= psdiv_pkg::PRIME) ?
                   term_data.dividend_term - psdiv_pkg::PRIME : term_data.dividend_term;
    assign b_red = (term_data.divisor_term >= psdiv_pkg::PRIME) ?
                   term_data.divisor_term - psdiv_pkg::PRIME : term_data.divisor_term;

    assign div_we    = accept && !idx_over;
    assign rd_en     = (state_reg == S_RUN);
    assign div_diff  = idx_reg - psdiv_pkg::CNT_W'(j_reg);
    assign div_raddr = div_diff[psdiv_pkg::IDX_W-1:0];
    assign run_last  = (psdiv_pkg::CNT_W'(j_reg) == idx_reg - psdiv_pkg::CNT_W'(1));
    assign out_free  = !quot_valid_reg || !quot_stall;
    assign quo_we    = (state_reg == S_DONE) && out_free && !over_reg;

    // add the prime back only when the difference goes negative
    assign q_val = (a_reg >= acc) ? a_reg - acc : a_reg + psdiv_pkg::PRIME - acc;

    assign mac_ctl.valid = rd_valid_reg;
    assign mac_ctl.clear = accept;

    psdiv_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .opa   (quo_rd_reg),
        .opb   (div_rd_reg),
        .acc   (acc),
        .busy  (mac_busy)
    );

    always_ff @(posedge clk)
    begin
        if (div_we)
        begin
            div_mem[idx_reg[psdiv_pkg::IDX_W-1:0]] <= b_red;
        end
        if (rd_en)
        begin
            div_rd_reg <= div_mem[div_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (quo_we)
        begin
            quo_mem[idx_reg[psdiv_pkg::IDX_W-1:0]] <= q_val;
        end
        if (rd_en)
        begin
            quo_rd_reg <= quo_mem[j_reg];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        j_next          = j_reg;
        a_next          = a_reg;
        last_next       = last_reg;
        over_next       = over_reg;
        rd_valid_next   = 1'b0;
        quot_valid_next = quot_valid_reg && quot_stall;
        quot_data_next  = quot_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (term_valid)
                begin
                    a_next    = a_red;
                    last_next = term_data.series_end;
                    over_next = idx_over;
                    j_next    = '0;
                    if (idx_over || idx_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                rd_valid_next = 1'b1;
                j_next        = j_reg + psdiv_pkg::IDX_W'(1);
                if (run_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_valid_reg && !mac_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    quot_valid_next               = 1'b1;
                    quot_data_next.quotient_term  = over_reg ? '0 : q_val;
                    quot_data_next.end_of_series  = last_reg;
                    quot_data_next.too_many_terms = over_reg;
                    if (last_reg)
                    begin
                        idx_next = '0;
                    end
                    else if (!over_reg)
                    begin
                        idx_next = idx_reg + psdiv_pkg::CNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            j_reg          <= '0;
            a_reg          <= '0;
            last_reg       <= 1'b0;
            over_reg       <= 1'b0;
            rd_valid_reg   <= 1'b0;
            quot_valid_reg <= 1'b0;
            quot_data_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            j_reg          <= j_next;
            a_reg          <= a_next;
            last_reg       <= last_next;
            over_reg       <= over_next;
            rd_valid_reg   <= rd_valid_next;
            quot_valid_reg <= quot_valid_next;
            quot_data_reg  <= quot_data_next;
        end
    end

    assign quot_valid = quot_valid_reg;
    assign quot_data  = quot_data_reg;

endmodule
